// ===== rtl/core/transformed_aabb_bounds_assert.svh =====
// Assertion macros for the transformed box bounds block
`ifndef TRANSFORMED_AABB_BOUNDS_ASSERT_SVH
`define TRANSFORMED_AABB_BOUNDS_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TAABB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("taabb assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TAABB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("taabb assertion failed");

`endif

// ===== rtl/core/taabb_pkg.sv =====
// Types and constants shared by the transformed box bounds pipeline
package taabb_pkg;

  localparam int unsigned FracBits = 16;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [47:0] prod_t;   // 64-bit product >>> 16
  typedef logic signed [48:0] psum_t;   // sum of two terms
  typedef logic signed [49:0] tsum_t;   // sum of four terms

  typedef q16_t  [2:0][3:0] mat_t;      // [row][col], row0_col0 lowest
  typedef q16_t  [2:0]      vec3_t;     // x lowest
  typedef prod_t [2:0][2:0] prod3_t;    // [row][col]
  typedef psum_t [2:0]      psum3_t;
  typedef logic  [2:0][30:0] half3_t;

  // register indexes of the configuration port
  localparam logic [2:0] RegObjMinX = 3'd0;
  localparam logic [2:0] RegObjMinY = 3'd1;
  localparam logic [2:0] RegObjMinZ = 3'd2;
  localparam logic [2:0] RegObjMaxX = 3'd3;
  localparam logic [2:0] RegObjMaxY = 3'd4;
  localparam logic [2:0] RegObjMaxZ = 3'd5;

  typedef struct packed {
    prod3_t pmin;   // entry times object minimum
    prod3_t pmax;   // entry times object maximum
    vec3_t  trans;
  } mul_t;

  typedef struct packed {
    prod3_t lo;
    prod3_t hi;
    vec3_t  trans;
  } mm_t;

  typedef struct packed {
    half3_t half;
    vec3_t  center;
    vec3_t  wmax;
    vec3_t  wmin;
  } res_t;

endpackage

// ===== rtl/core/taabb_mul.sv =====
// Stage 1: eighteen products of matrix entries with object box bounds
module taabb_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  taabb_pkg::mat_t    mat_i,
  input  taabb_pkg::vec3_t   obj_min_i,
  input  taabb_pkg::vec3_t   obj_max_i,
  output logic               valid_o,
  input  logic               ready_i,
  output taabb_pkg::mul_t    data_o
);
  import taabb_pkg::*;

  logic signed [63:0] pmin_full [3][3];
  logic signed [63:0] pmax_full [3][3];
  mul_t data_d, data_q;
  logic valid_q;

  always_comb begin
    data_d = data_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pmin_full[r][c] = $signed(mat_i[r][c]) * $signed(obj_min_i[c]);
        pmax_full[r][c] = $signed(mat_i[r][c]) * $signed(obj_max_i[c]);
        data_d.pmin[r][c] = pmin_full[r][c][63:FracBits];
        data_d.pmax[r][c] = pmax_full[r][c][63:FracBits];
      end
      data_d.trans[r] = mat_i[r][3];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/taabb_minmax.sv =====
// Stage 2: per-term minimum and maximum over the two box bounds
module taabb_minmax (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  taabb_pkg::mul_t  data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output taabb_pkg::mm_t   data_o
);
  import taabb_pkg::*;

  mm_t  data_d, data_q;
  logic valid_q;

  // terms are independent per column, so the corner extremes split into them
  always_comb begin
    data_d = data_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ($signed(data_i.pmin[r][c]) < $signed(data_i.pmax[r][c])) begin
          data_d.lo[r][c] = data_i.pmin[r][c];
          data_d.hi[r][c] = data_i.pmax[r][c];
        end else begin
          data_d.lo[r][c] = data_i.pmax[r][c];
          data_d.hi[r][c] = data_i.pmin[r][c];
        end
      end
    end
    data_d.trans = data_i.trans;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/taabb_sum.sv =====
// Stages 3 and 4: add terms and translation, saturate to 32 bits
module taabb_sum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  taabb_pkg::mm_t    data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output taabb_pkg::vec3_t  lo_o,
  output taabb_pkg::vec3_t  hi_o
);
  import taabb_pkg::*;

  // stage 3: pair sums
  psum3_t lo01_d, lo01_q, lo2t_d, lo2t_q;
  psum3_t hi01_d, hi01_q, hi2t_d, hi2t_q;
  logic   valid_a_q, ready_a;
  // stage 4: full sum and saturation
  tsum_t  lo_tot [3];
  tsum_t  hi_tot [3];
  vec3_t  lo_d, lo_q, hi_d, hi_q;
  logic   valid_b_q;

  function automatic q16_t sat32(input tsum_t v);
    q16_t res;
    if (v[49:31] == {19{v[49]}}) begin
      res = v[31:0];
    end else if (v[49]) begin
      res = {1'b1, 31'd0};
    end else begin
      res = {1'b0, {31{1'b1}}};
    end
    return res;
  endfunction

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lo01_d[r] = {data_i.lo[r][0][47], data_i.lo[r][0]} + {data_i.lo[r][1][47], data_i.lo[r][1]};
      hi01_d[r] = {data_i.hi[r][0][47], data_i.hi[r][0]} + {data_i.hi[r][1][47], data_i.hi[r][1]};
      lo2t_d[r] = {data_i.lo[r][2][47], data_i.lo[r][2]}
                + {{17{data_i.trans[r][31]}}, data_i.trans[r]};
      hi2t_d[r] = {data_i.hi[r][2][47], data_i.hi[r][2]}
                + {{17{data_i.trans[r][31]}}, data_i.trans[r]};
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lo_tot[r] = {lo01_q[r][48], lo01_q[r]} + {lo2t_q[r][48], lo2t_q[r]};
      hi_tot[r] = {hi01_q[r][48], hi01_q[r]} + {hi2t_q[r][48], hi2t_q[r]};
      lo_d[r]   = sat32(lo_tot[r]);
      hi_d[r]   = sat32(hi_tot[r]);
    end
  end

  assign ready_a = !valid_b_q || ready_i;
  assign ready_o = !valid_a_q || ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_o) begin
        valid_a_q <= valid_i;
      end
      if (ready_a) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lo01_q <= lo01_d;
      lo2t_q <= lo2t_d;
      hi01_q <= hi01_d;
      hi2t_q <= hi2t_d;
    end
    if (valid_a_q && ready_a) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign valid_o = valid_b_q;
  assign lo_o    = lo_q;
  assign hi_o    = hi_q;

endmodule

// ===== rtl/core/taabb_fin.sv =====
// Stage 5: centre and half-lengths into the output register
module taabb_fin (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  taabb_pkg::vec3_t  lo_i,
  input  taabb_pkg::vec3_t  hi_i,
  output logic              valid_o,
  input  logic              ready_i,
  output taabb_pkg::res_t   res_o
);
  import taabb_pkg::*;

  logic signed [32:0] sum [3];
  logic signed [32:0] dif [3];
  res_t res_d, res_q;
  logic valid_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = {lo_i[r][31], lo_i[r]} + {hi_i[r][31], hi_i[r]};
      dif[r] = {hi_i[r][31], hi_i[r]} - {lo_i[r][31], lo_i[r]};
      res_d.wmin[r]   = lo_i[r];
      res_d.wmax[r]   = hi_i[r];
      res_d.center[r] = sum[r][32:1];   // arithmetic halving
      res_d.half[r]   = dif[r][31:1];   // never negative
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/core/transformed_aabb_bounds.sv =====
// Top level: world-space bounding box of the configured object box under an affine matrix
//
//  channel   dir   handshake                      payload
//  s_axis    in    s_axis_tvalid/s_axis_tready    3x4 matrix, 384 bits
//  m_axis    out   m_axis_tvalid/m_axis_tready    min, max, centre, half, 381 bits
//  apb       in    psel/penable/pwrite/pready     object box min and max
//
// One item per cycle sustained while m_axis is not stalled; five register stages.
// Stage 1 holds the eighteen 32x32 multipliers; stages 2 to 5 are min/max, pair add,
// full add with saturation, and centre/half into the output register.
// Reset clears every stage valid bit and the six box registers to zero.
// A stall on m_axis backs up stage by stage; empty stages still fill, so bubbles close.
module transformed_aabb_bounds (
  input  logic          clk_i,
  input  logic          rst_ni,
  // items in
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // row0_col0, row0_col1, row0_col2, row0_col3, row1_col0 .. row2_col3, 32 bits each
  input  logic [383:0]  s_axis_tdata,
  // items out
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // world_min_x/y/z, world_max_x/y/z, center_x/y/z (32 bits each),
  // half_x/y/z (31 bits each), 3 zero bits
  output logic [383:0]  m_axis_tdata,
  // configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import taabb_pkg::*;

  `include "transformed_aabb_bounds_assert.svh"

  vec3_t obj_min_q, obj_max_q;
  logic  [2:0] reg_idx;
  logic  cfg_wr;

  logic  mul_valid, mul_ready;
  mul_t  mul_data;
  logic  mm_valid, mm_ready;
  mm_t   mm_data;
  logic  sum_valid, sum_ready;
  vec3_t sum_lo, sum_hi;
  res_t  res;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_min_q <= '0;
      obj_max_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegObjMinX: obj_min_q[0] <= pwdata;
        RegObjMinY: obj_min_q[1] <= pwdata;
        RegObjMinZ: obj_min_q[2] <= pwdata;
        RegObjMaxX: obj_max_q[0] <= pwdata;
        RegObjMaxY: obj_max_q[1] <= pwdata;
        RegObjMaxZ: obj_max_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegObjMinX: prdata = obj_min_q[0];
      RegObjMinY: prdata = obj_min_q[1];
      RegObjMinZ: prdata = obj_min_q[2];
      RegObjMaxX: prdata = obj_max_q[0];
      RegObjMaxY: prdata = obj_max_q[1];
      RegObjMaxZ: prdata = obj_max_q[2];
      default:    prdata = '0;
    endcase
  end

  // user must change box registers only while idle, not enforced; stage 1 reads them
  taabb_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .mat_i     (mat_t'(s_axis_tdata)),
    .obj_min_i (obj_min_q),
    .obj_max_i (obj_max_q),
    .valid_o   (mul_valid),
    .ready_i   (mul_ready),
    .data_o    (mul_data)
  );

  taabb_minmax u_minmax (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (mul_ready),
    .data_i  (mul_data),
    .valid_o (mm_valid),
    .ready_i (mm_ready),
    .data_o  (mm_data)
  );

  taabb_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mm_valid),
    .ready_o (mm_ready),
    .data_i  (mm_data),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .lo_o    (sum_lo),
    .hi_o    (sum_hi)
  );

  taabb_fin u_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .lo_i    (sum_lo),
    .hi_i    (sum_hi),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {3'b000, res};

  // input side only stalls when the whole pipe is full behind a blocked output
  `TAABB_ASSERT_NOW(a_stall_src, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  // the world box is always ordered; checked on x and z
  `TAABB_ASSERT_NOW(a_ordered_x, clk_i, rst_ni, m_axis_tvalid, $signed(res.wmin[0]) <= $signed(res.wmax[0]))
  `TAABB_ASSERT_NOW(a_ordered_z, clk_i, rst_ni, m_axis_tvalid, $signed(res.wmin[2]) <= $signed(res.wmax[2]))
  // an output item that is not taken keeps m_axis_tvalid high
  `TAABB_ASSERT_NEXT(a_out_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

// ===== tb/transformed_aabb_bounds_tb.sv =====
// Self-checking testbench for the transformed box bounds block: random matrices, APB box setup
`timescale 1ns / 1ps

module transformed_aabb_bounds_tb;
  import taabb_pkg::*;

  // Q16.16 corner values used by the directed items
  localparam q16_t QOne  = 32'sh0001_0000;
  localparam q16_t QHalf = 32'sh0000_8000;
  localparam q16_t QMax  = 32'sh7FFF_FFFF;
  localparam q16_t QMin  = 32'sh8000_0000;

  // saturation bounds for the wide corner sums
  localparam longint SatMax = 64'sd2147483647;
  localparam longint SatMin = -64'sd2147483648;

  localparam int IdlePct    = 32;     // chance of a gap per cycle, either side
  localparam int HoldCycles = 300;    // long receiver hold-off, fills the pipe
  localparam int DrainWait  = 8;      // pipeline is five deep, a little slack
  localparam int CycleLimit = 100000;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // row0_col0 .. row0_col3, row1_col0 .. row1_col3, row2_col0 .. row2_col3, 32 bits each
  logic [383:0] s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // world_min_x/y/z, world_max_x/y/z, center_x/y/z (32 bits each), half_x/y/z (31 bits each)
  logic [383:0] m_axis_tdata;
  logic         psel          = 1'b0;
  logic         penable       = 1'b0;
  logic         pwrite        = 1'b0;
  logic [4:0]   paddr         = '0;
  logic [31:0]  pwdata        = '0;
  logic [31:0]  prdata;
  logic         pready;

  // our own copy of the object box, kept in step with every register write
  vec3_t box_min = '0;
  vec3_t box_max = '0;

  mat_t pending_mats_q[$];     // matrices waiting to be offered
  res_t expected_bounds_q[$];  // predicted boxes, oldest first

  int src_idle_pct  = IdlePct;
  int sink_idle_pct = IdlePct;
  int fail_count    = 0;
  int cycle_count   = 0;
  int hold_left     = 0;
  bit hold_request  = 1'b0;
  bit hold_done     = 1'b0;

  transformed_aabb_bounds dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // World box of the current object box under one matrix. All eight corners are
  // taken from the min/max registers per axis, so an inverted box still gives an
  // ordered result. Each product is floored by the >>> 16, the sum saturates once.
  function automatic res_t box_bounds(input mat_t m);
    res_t   res;
    longint acc;
    longint lo [3];
    longint hi [3];
    q16_t   corner [3];
    for (int k = 0; k < 8; k++) begin
      for (int c = 0; c < 3; c++) corner[c] = k[c] ? box_max[c] : box_min[c];
      for (int r = 0; r < 3; r++) begin
        acc = longint'($signed(m[r][3]));
        for (int c = 0; c < 3; c++)
          acc += (longint'($signed(m[r][c])) * longint'($signed(corner[c]))) >>> FracBits;
        if (acc > SatMax) acc = SatMax;
        else if (acc < SatMin) acc = SatMin;
        if (k == 0 || acc < lo[r]) lo[r] = acc;
        if (k == 0 || acc > hi[r]) hi[r] = acc;
      end
    end
    for (int r = 0; r < 3; r++) begin
      res.wmin[r]   = q16_t'(lo[r]);
      res.wmax[r]   = q16_t'(hi[r]);
      res.center[r] = q16_t'((lo[r] + hi[r]) >>> 1);   // floor of the mean
      res.half[r]   = 31'((hi[r] - lo[r]) >>> 1);
    end
    return res;
  endfunction

  // mostly small values, a good share of full-range ones, and the odd extreme
  function automatic q16_t rand_q16();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return QMax;
          1:       return QMin;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return q16_t'($urandom_range(32'h0008_0000)) - q16_t'(32'h0004_0000);
    endcase
  endfunction

  function automatic vec3_t vec3(input q16_t x, input q16_t y, input q16_t z);
    vec3_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    return v;
  endfunction

  // uniform scale on the diagonal plus translation
  function automatic mat_t diag(input q16_t s, input vec3_t t);
    mat_t m;
    m = '0;
    for (int r = 0; r < 3; r++) begin
      m[r][r] = s;
      m[r][3] = t[r];
    end
    return m;
  endfunction

  function automatic mat_t rand_mat();
    mat_t m;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) m[r][c] = rand_q16();
    return m;
  endfunction

  // APB write: setup, then access; register takes the value at the access edge
  task automatic write_reg(input logic [2:0] idx, input q16_t value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegObjMinX: box_min[0] = value;
      RegObjMinY: box_min[1] = value;
      RegObjMinZ: box_min[2] = value;
      RegObjMaxX: box_max[0] = value;
      RegObjMaxY: box_max[1] = value;
      RegObjMaxZ: box_max[2] = value;
      default: ;
    endcase
  endtask

  task automatic set_box(input vec3_t mn, input vec3_t mx);
    write_reg(RegObjMinX, mn[0]);
    write_reg(RegObjMinY, mn[1]);
    write_reg(RegObjMinZ, mn[2]);
    write_reg(RegObjMaxX, mx[0]);
    write_reg(RegObjMaxY, mx[1]);
    write_reg(RegObjMaxZ, mx[2]);
  endtask

  // every item gives a result, so an empty scoreboard means the pipe is empty
  task automatic drain();
    while (pending_mats_q.size() != 0 || expected_bounds_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic queue_random(input int count);
    @(negedge clk_i);
    repeat (count) pending_mats_q.push_back(rand_mat());
  endtask

  // Driver: offers the head of the queue, holds it until taken. The prediction is
  // made at the accepting edge, with the box that is live for this phase.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      expected_bounds_q.push_back(box_bounds(pending_mats_q.pop_front()));
    if (s_axis_tvalid && !s_axis_tready) begin
      // item still on offer, leave it alone
    end else if (pending_mats_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pending_mats_q[0];
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // long receiver hold-off, run once on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int axis,
                             input q16_t want, input q16_t got);
    if (got !== want) begin
      $display("%0t: %s[%0d] expected %0d, got %0d", $time, name, axis, want, got);
      fail_count++;
    end
  endtask

  // Monitor: compares each result with the oldest prediction, field by field
  always @(posedge clk_i) begin : monitor
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[380:0];
      if (expected_bounds_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, got);
        fail_count++;
      end else begin
        want = expected_bounds_q.pop_front();
        for (int r = 0; r < 3; r++) begin
          check_field("world_min", r, want.wmin[r], got.wmin[r]);
          check_field("world_max", r, want.wmax[r], got.wmax[r]);
          check_field("center", r, want.center[r], got.center[r]);
          check_field("half", r, {1'b0, want.half[r]}, {1'b0, got.half[r]});
        end
      end
    end
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("transformed_aabb_bounds_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    mat_t  m;
    vec3_t pt;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // box still at reset (all zero): every corner is the origin, result is the translation
    @(negedge clk_i);
    pending_mats_q.push_back(diag(QOne, vec3(QMax, QMin, 32'sh0003_8000)));
    pending_mats_q.push_back(rand_mat());
    drain();

    // unit box [-1, 1] on every axis
    set_box(vec3(-QOne, -QOne, -QOne), vec3(QOne, QOne, QOne));
    @(negedge clk_i);
    pending_mats_q.push_back(diag(QOne, '0));
    pending_mats_q.push_back(diag(QOne, vec3(QMax, QMin, '0)));   // translation saturates
    pending_mats_q.push_back(diag(-QOne, '0));
    pending_mats_q.push_back(diag(QHalf, vec3(QOne, -QOne, QHalf)));
    m = '1;                                                        // tiny negatives, floored
    pending_mats_q.push_back(m);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) m[r][c] = QMax;
    pending_mats_q.push_back(m);                                   // overflow both ways
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++) m[r][c] = QMin;
    pending_mats_q.push_back(m);
    m = diag('0, vec3(32'sh0010_0000, -32'sh0002_0000, '0));     // 90 degrees about z
    m[0][1] = -QOne;
    m[1][0] = QOne;
    m[2][2] = QOne;
    pending_mats_q.push_back(m);
    pending_mats_q.push_back(diag('0, vec3(rand_q16(), rand_q16(), rand_q16())));
    drain();

    // inverted box: min above max on every axis, world box still ordered
    set_box(vec3(32'sh0002_0000, QOne, QHalf), vec3(-QOne, -32'sh0003_0000, -QHalf));
    @(negedge clk_i);
    pending_mats_q.push_back(diag(QOne, '0));
    pending_mats_q.push_back(diag(-32'sh0002_0000, vec3(QOne, QOne, QOne)));
    pending_mats_q.push_back(rand_mat());
    drain();

    // widest box possible: corners at both ends of the range
    set_box(vec3(QMin, QMin, QMin), vec3(QMax, QMax, QMax));
    @(negedge clk_i);
    pending_mats_q.push_back(diag(QOne, '0));
    pending_mats_q.push_back(diag(QHalf, vec3(QMin, QMax, '0)));
    pending_mats_q.push_back(diag('0, vec3(QMax, QMin, QOne)));
    queue_random(40);
    drain();

    // zero-width box: a single point
    pt = vec3(rand_q16(), rand_q16(), rand_q16());
    set_box(pt, pt);
    queue_random(20);
    drain();

    // random boxes; one phase with no idling at all, one with the long hold-off
    for (int phase = 0; phase < 8; phase++) begin
      set_box(vec3(rand_q16(), rand_q16(), rand_q16()), vec3(rand_q16(), rand_q16(), rand_q16()));
      src_idle_pct  = (phase == 2) ? 0 : IdlePct;
      sink_idle_pct = (phase == 2) ? 0 : IdlePct;
      queue_random(85);
      if (phase == 5) hold_request = 1'b1;
      drain();
    end

    if (fail_count == 0)
      $display("transformed_aabb_bounds_tb: PASS");
    else
      $display("transformed_aabb_bounds_tb: FAIL");
    $finish;
  end

endmodule
